[sv/gnar_pkg.sv]
// shared types and constants for the gamepad navigation auto-repeat block
`default_nettype none
package gnar_pkg;

  localparam int GNAR_TIME_BITS = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STICK_DEADZONE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL   = 2'd3;

  // reset values of the registers
  localparam logic [14:0] DEADZONE_RST  = 15'd8000;
  localparam logic [7:0]  THRESHOLD_RST = 8'd128;
  localparam logic [15:0] DELAY_RST     = 16'd400;
  localparam logic [15:0] INTERVAL_RST  = 16'd100;

  // button word bit positions
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_LS    = 8;
  localparam int BTN_RS    = 9;
  localparam int BTN_GUIDE = 10;
  localparam int BTN_A     = 12;
  localparam int BTN_B     = 13;
  localparam int BTN_X     = 14;
  localparam int BTN_Y     = 15;

  // direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [15:0]        button_word;
    logic [7:0]         left_pull;
    logic [7:0]         right_pull;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [31:0]        time_ms;
  } gnar_in_t;

  typedef struct packed {
    logic       nav_fire;
    logic [1:0] nav_dir;
    logic       accept_edge;
    logic       back_edge;
    logic       context_edge;
    logic       quick_edge;
    logic       guide_edge;
    logic       section_prev_edge;
    logic       section_next_edge;
    logic       page_prev_edge;
    logic       page_fwd_edge;
    logic       any_action;
  } gnar_out_t;

  // what the decoder sees in one poll
  typedef struct packed {
    logic       active;
    logic [1:0] dir;
    logic       stick;
    logic       left_pressed;
    logic       right_pressed;
  } gnar_look_t;

  // remainder unit handshake
  typedef struct packed {
    logic busy;
    logic done;
  } gnar_rem_stat_t;

endpackage
`default_nettype wire

[sv/gnar_look.sv]
// direction resolution and trigger threshold decode for one poll
`default_nettype none
module gnar_look
  import gnar_pkg::*;
(
  input  gnar_in_t    beat,
  input  logic [14:0] deadzone,
  input  logic [7:0]  threshold,
  output gnar_look_t  look
);

  logic [15:0] ax;
  logic [15:0] ay;
  logic        centered;

  // magnitudes, most negative value gives 32768
  assign ax = beat.stick_x[15] ? (~beat.stick_x + 16'd1) : beat.stick_x;
  assign ay = beat.stick_y[15] ? (~beat.stick_y + 16'd1) : beat.stick_y;
  assign centered = (ax < {1'b0, deadzone}) && (ay < {1'b0, deadzone});

  always_comb begin
    look.left_pressed  = beat.left_pull >= threshold;
    look.right_pressed = beat.right_pull >= threshold;
    look.active        = 1'b1;
    look.stick         = 1'b0;
    look.dir           = DIR_UP;
    if (beat.button_word[BTN_UP]) begin
      look.dir = DIR_UP;
    end else if (beat.button_word[BTN_DOWN]) begin
      look.dir = DIR_DOWN;
    end else if (beat.button_word[BTN_LEFT]) begin
      look.dir = DIR_LEFT;
    end else if (beat.button_word[BTN_RIGHT]) begin
      look.dir = DIR_RIGHT;
    end else if (centered) begin
      look.active = 1'b0;
    end else begin
      look.stick = 1'b1;
      if (ay >= ax) begin
        look.dir = (!beat.stick_y[15] && beat.stick_y != 16'sd0) ? DIR_UP : DIR_DOWN;
      end else begin
        look.dir = beat.stick_x[15] ? DIR_LEFT : DIR_RIGHT;
      end
    end
  end

endmodule
`default_nettype wire

[sv/gnar_rem.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none
module gnar_rem
  import gnar_pkg::*;
#(
  parameter int TIME_BITS = GNAR_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [15:0]          divisor,
  output gnar_rem_stat_t       stat,
  output logic [15:0]          rem
);

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS-1:0] dvd_r, dvd_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [16:0]          shifted;
  logic [16:0]          diff;

  assign shifted = {rem_r, dvd_r[TIME_BITS-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = CNT_W'(TIME_BITS);
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // subtract and compare
      rem_nxt = (shifted >= {1'b0, divisor}) ? diff[15:0] : shifted[15:0];
      dvd_nxt = {dvd_r[TIME_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

[sv/gamepad_navigation_auto_repeat.sv]
// top level: gamepad navigation mapper with edge detect and auto-repeat
`default_nettype none
// Takes one pad poll per input beat and returns exactly one result beat per poll.
// A poll with no repeat catch-up is decoded into a pending register, then loaded
// into the output register before the next poll can be accepted. A poll whose
// repeat is due also goes through the divide state: the next fire time is set to
// now - ((now - next_fire_time) mod interval) + interval, and the remainder comes
// from a bit-serial subtract/compare unit that handles one time bit per cycle.
// in_stall is high while a poll is being worked on; a finished result waiting
// in the output register does not block the next poll from being accepted.
// Configuration writes are taken on any cycle with cfg_we high and should only
// happen while the block is idle.
module gamepad_navigation_auto_repeat
  import gnar_pkg::*;
#(
  parameter int TIME_BITS = GNAR_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gnar_in_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gnar_out_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } gnar_state_t;

  gnar_state_t state_r, state_nxt;

  // configuration
  logic [14:0] deadzone_r;
  logic [7:0]  threshold_r;
  logic [15:0] delay_r;
  logic [15:0] interval_r;

  // pad history and repeat state
  logic [15:0]          last_buttons_r, last_buttons_nxt;
  logic                 last_left_r, last_left_nxt;
  logic                 last_right_r, last_right_nxt;
  logic                 repeating_r, repeating_nxt;
  logic [1:0]           held_dir_r, held_dir_nxt;
  logic                 held_stick_r, held_stick_nxt;
  logic [TIME_BITS-1:0] nft_r, nft_nxt;

  // work registers
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [15:0]          iv_r, iv_nxt;
  gnar_out_t            pend_r, pend_nxt;
  gnar_out_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 in_acc;
  logic                 div_start;
  gnar_look_t           look;
  gnar_rem_stat_t       rem_stat;
  logic [15:0]          rem;
  logic [15:0]          pressed;

  // width adaptation of the 32-bit time field and the 16-bit quantities
  logic [TIME_BITS+31:0] now_wide;
  logic [TIME_BITS+15:0] delay_wide;
  logic [TIME_BITS+15:0] iv_wide;
  logic [TIME_BITS+15:0] rem_wide;
  logic [TIME_BITS-1:0]  now_in;
  logic [TIME_BITS-1:0]  dividend;

  assign now_wide   = {{TIME_BITS{1'b0}}, in_beat.time_ms};
  assign delay_wide = {{TIME_BITS{1'b0}}, delay_r};
  assign iv_wide    = {{TIME_BITS{1'b0}}, iv_r};
  assign rem_wide   = {{TIME_BITS{1'b0}}, rem};
  assign now_in     = now_wide[TIME_BITS-1:0];
  assign dividend   = now_in - nft_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pressed  = in_beat.button_word & ~last_buttons_r;

  gnar_look u_look (
    .beat      (in_beat),
    .deadzone  (deadzone_r),
    .threshold (threshold_r),
    .look      (look)
  );

  gnar_rem #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (iv_r),
    .stat     (rem_stat),
    .rem      (rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= DEADZONE_RST;
      threshold_r <= THRESHOLD_RST;
      delay_r     <= DELAY_RST;
      interval_r  <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STICK_DEADZONE:    deadzone_r  <= cfg_wdata[14:0];
        REG_TRIGGER_THRESHOLD: threshold_r <= cfg_wdata[7:0];
        REG_INITIAL_DELAY:     delay_r     <= cfg_wdata;
        REG_REPEAT_INTERVAL:   interval_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    last_buttons_nxt = last_buttons_r;
    last_left_nxt    = last_left_r;
    last_right_nxt   = last_right_r;
    repeating_nxt    = repeating_r;
    held_dir_nxt     = held_dir_r;
    held_stick_nxt   = held_stick_r;
    nft_nxt          = nft_r;
    now_nxt          = now_r;
    iv_nxt           = iv_r;
    pend_nxt         = pend_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;
    div_start        = 1'b0;

    // output beat taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt   = now_in;
          state_nxt = S_OUT;

          pend_nxt.nav_fire          = 1'b0;
          pend_nxt.nav_dir           = DIR_UP;
          pend_nxt.accept_edge       = pressed[BTN_A];
          pend_nxt.back_edge         = pressed[BTN_B];
          pend_nxt.context_edge      = pressed[BTN_X];
          pend_nxt.quick_edge        = pressed[BTN_Y];
          pend_nxt.guide_edge        = pressed[BTN_GUIDE];
          pend_nxt.section_prev_edge = pressed[BTN_LS];
          pend_nxt.section_next_edge = pressed[BTN_RS];
          pend_nxt.page_prev_edge    = look.left_pressed && !last_left_r;
          pend_nxt.page_fwd_edge     = look.right_pressed && !last_right_r;

          if (!look.active) begin
            // direction released
            repeating_nxt = 1'b0;
          end else if (!repeating_r || held_dir_r != look.dir ||
                       held_stick_r != look.stick) begin
            // new direction or new source fires at once
            pend_nxt.nav_fire = 1'b1;
            pend_nxt.nav_dir  = look.dir;
            repeating_nxt     = 1'b1;
            held_dir_nxt      = look.dir;
            held_stick_nxt    = look.stick;
            nft_nxt           = now_in + delay_wide[TIME_BITS-1:0];
          end else if (now_in >= nft_r) begin
            // repeat due, work out the catch-up in the remainder unit
            pend_nxt.nav_fire = 1'b1;
            pend_nxt.nav_dir  = look.dir;
            iv_nxt            = (interval_r == 16'd0) ? 16'd1 : interval_r;
            div_start         = 1'b1;
            state_nxt         = S_DIV;
          end

          pend_nxt.any_action = pend_nxt.nav_fire | pend_nxt.accept_edge |
                                pend_nxt.back_edge | pend_nxt.context_edge |
                                pend_nxt.quick_edge | pend_nxt.guide_edge |
                                pend_nxt.section_prev_edge |
                                pend_nxt.section_next_edge |
                                pend_nxt.page_prev_edge | pend_nxt.page_fwd_edge;

          last_buttons_nxt = in_beat.button_word;
          last_left_nxt    = look.left_pressed;
          last_right_nxt   = look.right_pressed;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          // next fire lands one interval past the last missed slot
          nft_nxt   = now_r - rem_wide[TIME_BITS-1:0] + iv_wide[TIME_BITS-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      last_buttons_r <= '0;
      last_left_r    <= 1'b0;
      last_right_r   <= 1'b0;
      repeating_r    <= 1'b0;
      held_dir_r     <= DIR_UP;
      held_stick_r   <= 1'b0;
      nft_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_buttons_r <= last_buttons_nxt;
      last_left_r    <= last_left_nxt;
      last_right_r   <= last_right_nxt;
      repeating_r    <= repeating_nxt;
      held_dir_r     <= held_dir_nxt;
      held_stick_r   <= held_stick_nxt;
      nft_r          <= nft_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    now_r  <= now_nxt;
    iv_r   <= iv_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // remainder result only arrives while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> state_r == S_DIV)
    else $error("remainder done outside divide state");

  // divide state always has the unit working or finishing
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_stat.busy || rem_stat.done))
    else $error("divide state with idle remainder unit");

  // a catch-up accept must start the unit
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_DIV) |=> rem_stat.busy)
    else $error("catch-up did not start remainder unit");

  // no fire means direction reads as zero
  a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.nav_fire) |-> out_r.nav_dir == DIR_UP)
    else $error("direction set without fire");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the gamepad navigation block: directed table, then random polls against a predictor
`timescale 1ns / 100ps
module tb_top;
  import gnar_pkg::*;

  // run limits: a watchdog limit on the whole run and an idle tail after draining
  localparam int unsigned LIMIT_CYCLES = 600_000;
  localparam int          TAIL_CYCLES  = GNAR_TIME_BITS + 8;

  // button masks built from the package bit positions
  localparam logic [15:0] PAD_UP    = 16'h1 << BTN_UP;
  localparam logic [15:0] PAD_DOWN  = 16'h1 << BTN_DOWN;
  localparam logic [15:0] PAD_LEFT  = 16'h1 << BTN_LEFT;
  localparam logic [15:0] PAD_RIGHT = 16'h1 << BTN_RIGHT;
  localparam logic [15:0] PAD_ALL   = PAD_UP | PAD_DOWN | PAD_LEFT | PAD_RIGHT;
  localparam logic [15:0] ACTION_BTNS = (16'h1 << BTN_A) | (16'h1 << BTN_B) |
                                        (16'h1 << BTN_X) | (16'h1 << BTN_Y) |
                                        (16'h1 << BTN_GUIDE) | (16'h1 << BTN_LS) |
                                        (16'h1 << BTN_RS);

  // edge flag groups, ordered accept .. right trigger
  localparam logic [8:0] HITS_NONE  = 9'h000;
  localparam logic [8:0] HITS_ALL   = 9'h1FF;
  localparam logic [8:0] HITS_PAGES = 9'h003;

  typedef enum bit {ROW_POLL, ROW_CFG} row_kind_t;

  // one line of the directed table: either a poll or a register write
  typedef struct {
    row_kind_t              kind;
    gnar_in_t               poll;
    bit                     typed;
    gnar_out_t              want;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  gnar_in_t              in_beat   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_STICK_DEADZONE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  gnar_out_t             out_beat;

  gamepad_navigation_auto_repeat i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor copy of the registers, starting from their reset values
  logic [14:0] dz_cfg  = DEADZONE_RST;
  logic [7:0]  thr_cfg = THRESHOLD_RST;
  logic [15:0] dly_cfg = DELAY_RST;
  logic [15:0] ivl_cfg = INTERVAL_RST;

  // predictor copy of the block state
  logic [15:0] prev_buttons = '0;
  logic        prev_lp      = 1'b0;
  logic        prev_rp      = 1'b0;
  logic        rep_active   = 1'b0;
  logic [1:0]  held_dir     = DIR_UP;
  logic        held_stick   = 1'b0;
  logic [31:0] next_fire    = '0;

  gnar_out_t   nav_expect[$];    // results still owed by the block, oldest first
  stim_row_t   stim_tab[$];
  logic [31:0] cur_time = '0;    // running poll timestamp of the random part
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  bit          cfg_open  = 1'b0; // cfg_we still high from the last write
  int          errors    = 0;
  int          polls_sent   = 0;
  int          results_seen = 0;
  int          fires_seen   = 0;
  int          reg_writes   = 0;
  int unsigned cycles = 0;

  function automatic gnar_out_t mk_res(input logic fire, input logic [1:0] d,
                                       input logic [8:0] hits);
    gnar_out_t r;
    r.nav_fire = fire;
    r.nav_dir  = d;
    {r.accept_edge, r.back_edge, r.context_edge, r.quick_edge, r.guide_edge,
     r.section_prev_edge, r.section_next_edge, r.page_prev_edge, r.page_fwd_edge} = hits;
    r.any_action = fire | (|hits);
    return r;
  endfunction

  function automatic gnar_in_t mk_poll(input logic [15:0] btn, input logic [7:0] lp,
                                       input logic [7:0] rp, input logic signed [15:0] sx,
                                       input logic signed [15:0] sy, input logic [31:0] t);
    gnar_in_t p;
    p.button_word = btn;
    p.left_pull   = lp;
    p.right_pull  = rp;
    p.stick_x     = sx;
    p.stick_y     = sy;
    p.time_ms     = t;
    return p;
  endfunction

  // works out the result beat of one accepted poll and advances the predictor state
  function automatic gnar_out_t nav_predict(input gnar_in_t p);
    logic [15:0] rise;
    logic        lp, rp, on, stk, fire;
    logic [1:0]  d;
    int          ax, ay;
    logic [31:0] step, behind;
    logic [63:0] n_iv;
    gnar_out_t   r;
    rise = p.button_word & ~prev_buttons;
    lp   = p.left_pull >= thr_cfg;
    rp   = p.right_pull >= thr_cfg;
    ax   = ($signed(p.stick_x) < 0) ? -int'($signed(p.stick_x)) : int'($signed(p.stick_x));
    ay   = ($signed(p.stick_y) < 0) ? -int'($signed(p.stick_y)) : int'($signed(p.stick_y));
    on   = 1'b1;
    stk  = 1'b0;
    fire = 1'b0;
    d    = DIR_UP;
    // d-pad wins in fixed priority, else the dominant stick axis outside the deadzone
    if (p.button_word[BTN_UP]) d = DIR_UP;
    else if (p.button_word[BTN_DOWN]) d = DIR_DOWN;
    else if (p.button_word[BTN_LEFT]) d = DIR_LEFT;
    else if (p.button_word[BTN_RIGHT]) d = DIR_RIGHT;
    else if (ax < int'(dz_cfg) && ay < int'(dz_cfg)) on = 1'b0;
    else begin
      stk = 1'b1;
      if (ay >= ax) d = ($signed(p.stick_y) > 0) ? DIR_UP : DIR_DOWN;
      else d = ($signed(p.stick_x) < 0) ? DIR_LEFT : DIR_RIGHT;
    end
    if (!on) begin
      rep_active = 1'b0;
    end else if (!rep_active || held_dir != d || held_stick != stk) begin
      fire       = 1'b1;
      rep_active = 1'b1;
      held_dir   = d;
      held_stick = stk;
      next_fire  = p.time_ms + 32'(dly_cfg);
    end else if (p.time_ms >= next_fire) begin
      // catch-up: skip every interval already missed, one fire only
      step      = (ivl_cfg == 16'd0) ? 32'd1 : 32'(ivl_cfg);
      behind    = p.time_ms - next_fire;
      n_iv      = behind / step;
      n_iv      = n_iv + 64'd1;
      next_fire = next_fire + n_iv * step;
      fire      = 1'b1;
    end
    r = mk_res(fire, fire ? d : DIR_UP,
               {rise[BTN_A], rise[BTN_B], rise[BTN_X], rise[BTN_Y], rise[BTN_GUIDE],
                rise[BTN_LS], rise[BTN_RS], lp & ~prev_lp, rp & ~prev_rp});
    prev_buttons = p.button_word;
    prev_lp      = lp;
    prev_rp      = rp;
    return r;
  endfunction

  // mostly short idle runs, now and then a long one
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // timestamp steps scaled to the current delay and interval, with rare huge jumps
  function automatic logic [31:0] next_stamp();
    int          sel;
    logic [31:0] span;
    sel  = $urandom_range(0, 99);
    span = 32'(ivl_cfg) + 32'd1;
    if (sel >= 10) begin
      if (sel < 50) cur_time += $urandom_range(1, span);
      else if (sel < 80) cur_time += $urandom_range(0, 32'(dly_cfg) + span);
      else if (sel < 95) cur_time += $urandom_range(0, 8 * span + 32'(dly_cfg));
      else cur_time += $urandom;
    end
    return cur_time;
  endfunction

  // trigger values hovering around the threshold, or anything
  function automatic logic [7:0] pull_near();
    int v;
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    v = int'(thr_cfg) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // stick position whose dominant axis points toward d, at or beyond the deadzone
  function automatic void aim_stick(input logic [1:0] d, output logic signed [15:0] sx,
                                    output logic signed [15:0] sy);
    int mag, side;
    mag  = $urandom_range(int'(dz_cfg), 32768);
    side = $urandom_range(0, (mag > 0) ? mag - 1 : 0);
    if ($urandom_range(0, 1) == 1) side = -side;
    case (d)
      DIR_UP: begin
        sy = 16'((mag > 32767) ? 32767 : mag);
        sx = 16'(side);
      end
      DIR_DOWN: begin
        sy = 16'(-mag);
        sx = 16'(side);
      end
      DIR_LEFT: begin
        sx = 16'(-mag);
        sy = 16'(side);
      end
      default: begin
        sx = 16'((mag > 32767) ? 32767 : mag);
        sy = 16'(side);
      end
    endcase
  endfunction

  task automatic add_poll(input gnar_in_t p);
    stim_row_t row;
    row       = '{kind: ROW_POLL, default: '0};
    row.kind  = ROW_POLL;
    row.poll  = p;
    stim_tab.push_back(row);
  endtask

  task automatic add_checked(input gnar_in_t p, input gnar_out_t w);
    stim_row_t row;
    row       = '{kind: ROW_POLL, default: '0};
    row.kind  = ROW_POLL;
    row.poll  = p;
    row.typed = 1'b1;
    row.want  = w;
    stim_tab.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = '{kind: ROW_CFG, default: '0};
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    stim_tab.push_back(row);
  endtask

  // hands one poll beat to the block; the expectation is queued at the accepting edge
  task automatic send_poll(input gnar_in_t p, input bit typed, input gnar_out_t want);
    int        gap;
    gnar_out_t guess;
    if (cfg_open) begin
      cfg_we   <= 1'b0;
      cfg_open  = 1'b0;
    end
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= p;
    do @(posedge clk); while (in_stall);
    guess = nav_predict(p);
    // typed rows still run the predictor so its state keeps in step
    nav_expect.push_back(typed ? want : guess);
    polls_sent++;
  endtask

  // sender holds off until every owed result beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (nav_expect.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_open   = 1'b1;
    @(posedge clk);
    // registers keep only their own width
    case (idx)
      REG_STICK_DEADZONE:    dz_cfg  = data[14:0];
      REG_TRIGGER_THRESHOLD: thr_cfg = data[7:0];
      REG_INITIAL_DELAY:     dly_cfg = data;
      REG_REPEAT_INTERVAL:   ivl_cfg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_regs(input logic [15:0] dz, input logic [15:0] thr,
                          input logic [15:0] dly, input logic [15:0] ivl);
    wait_drained();
    cfg_write(REG_STICK_DEADZONE, dz);
    cfg_write(REG_TRIGGER_THRESHOLD, thr);
    cfg_write(REG_INITIAL_DELAY, dly);
    cfg_write(REG_REPEAT_INTERVAL, ivl);
  endtask

  // random polls: mostly held directions with random content, some pure noise
  task automatic run_random(input int count);
    int          sent, run_left;
    bit          noise, from_stick;
    logic [1:0]  d;
    logic [3:0]  above, pad;
    logic [15:0] keep_btns;
    gnar_in_t    p;
    sent      = 0;
    run_left  = 0;
    noise     = 1'b0;
    from_stick = 1'b0;
    d         = DIR_UP;
    keep_btns = '0;
    while (sent < count) begin
      if (run_left == 0) begin
        noise      = $urandom_range(0, 99) < 15;
        d          = 2'($urandom_range(0, 3));
        from_stick = $urandom_range(0, 1);
        run_left   = noise ? 1 : $urandom_range(1, 10);
      end
      if (noise) begin
        p = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 19) == 0) cur_time = p.time_ms;  // time may jump anywhere
        else p.time_ms = next_stamp();
      end else begin
        // action buttons change a bit at a time so edges stay meaningful
        if ($urandom_range(0, 2) == 0) keep_btns ^= 16'h1 << $urandom_range(4, 15);
        above = ~((4'b0010 << d) - 4'd1);
        pad   = from_stick ? 4'd0 : ((4'b0001 << d) | (4'($urandom) & above));
        p.button_word = (keep_btns & 16'hFFF0) | {12'd0, pad};
        if (from_stick) begin
          aim_stick(d, p.stick_x, p.stick_y);
          // a short dip toward the center releases the direction when it falls inside the deadzone
          if ($urandom_range(0, 11) == 0) begin
            p.stick_x = 16'($signed(p.stick_x) / 8);
            p.stick_y = 16'($signed(p.stick_y) / 8);
          end
        end else begin
          p.stick_x = 16'($urandom);
          p.stick_y = 16'($urandom);
        end
        p.left_pull  = pull_near();
        p.right_pull = pull_near();
        p.time_ms    = next_stamp();
      end
      run_left--;
      send_poll(p, 1'b0, '0);
      sent++;
      if (sent == count / 2) wait_drained();
    end
  endtask

  // receiver stalls in random runs while stalls_on is set
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left  = stall_left - 1;
    end else if (stalls_on && rst_n && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left  = pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string nm, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      errors++;
    end
  endtask

  // every accepted result beat is matched against the oldest expectation
  always @(posedge clk) begin
    gnar_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (nav_expect.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
      end else begin
        w = nav_expect.pop_front();
        check_field("nav_fire", w.nav_fire, out_beat.nav_fire);
        check_field("nav_dir", w.nav_dir, out_beat.nav_dir);
        check_field("accept_edge", w.accept_edge, out_beat.accept_edge);
        check_field("back_edge", w.back_edge, out_beat.back_edge);
        check_field("context_edge", w.context_edge, out_beat.context_edge);
        check_field("quick_edge", w.quick_edge, out_beat.quick_edge);
        check_field("guide_edge", w.guide_edge, out_beat.guide_edge);
        check_field("section_prev_edge", w.section_prev_edge, out_beat.section_prev_edge);
        check_field("section_next_edge", w.section_next_edge, out_beat.section_next_edge);
        check_field("page_prev_edge", w.page_prev_edge, out_beat.page_prev_edge);
        check_field("page_fwd_edge", w.page_fwd_edge, out_beat.page_fwd_edge);
        check_field("any_action", w.any_action, out_beat.any_action);
        results_seen++;
        if (out_beat.nav_fire === 1'b1) fires_seen++;
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d results owed", cycles, nav_expect.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, run at the reset register values first
    add_checked(mk_poll(16'h0, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd0),
                mk_res(1'b0, DIR_UP, HITS_NONE));
    // every action button and both triggers at full travel
    add_checked(mk_poll(ACTION_BTNS, 8'd255, 8'd255, 16'sd0, 16'sd0, 32'd1),
                mk_res(1'b0, DIR_UP, HITS_ALL));
    // held buttons and triggers just below threshold give nothing
    add_checked(mk_poll(ACTION_BTNS, 8'd127, 8'd127, 16'sd0, 16'sd0, 32'd2),
                mk_res(1'b0, DIR_UP, HITS_NONE));
    // triggers exactly at threshold
    add_checked(mk_poll(16'h0, 8'd128, 8'd128, 16'sd0, 16'sd0, 32'd3),
                mk_res(1'b0, DIR_UP, HITS_PAGES));
    // all four d-pad bits: up wins, fires at once
    add_checked(mk_poll(PAD_ALL, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd10),
                mk_res(1'b1, DIR_UP, HITS_NONE));
    // one millisecond short of the initial delay, then right on it
    add_checked(mk_poll(PAD_ALL, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd409),
                mk_res(1'b0, DIR_UP, HITS_NONE));
    add_checked(mk_poll(PAD_ALL, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd410),
                mk_res(1'b1, DIR_UP, HITS_NONE));
    // several intervals missed: one fire and catch-up
    add_poll(mk_poll(PAD_ALL, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1000));
    add_poll(mk_poll(PAD_ALL, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1010));
    // direction changes on the d-pad fire immediately
    add_checked(mk_poll(PAD_DOWN, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1011),
                mk_res(1'b1, DIR_DOWN, HITS_NONE));
    add_checked(mk_poll(PAD_LEFT | PAD_RIGHT, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1012),
                mk_res(1'b1, DIR_LEFT, HITS_NONE));
    add_checked(mk_poll(PAD_RIGHT, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1013),
                mk_res(1'b1, DIR_RIGHT, HITS_NONE));
    // stick: most negative axis, axis extremes, the diagonal, just inside the deadzone
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, -16'sd32768, 16'sd0, 32'd1014));
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, -16'sd32768, 16'sd32767, 32'd1015));
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, 16'sd8000, -16'sd8000, 32'd1016));
    add_checked(mk_poll(16'h0, 8'd0, 8'd0, 16'sd7999, -16'sd7999, 32'd1017),
                mk_res(1'b0, DIR_UP, HITS_NONE));
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, 16'sd0, 16'sd8000, 32'd1018));
    // same direction but from the d-pad now counts as a change of source
    add_poll(mk_poll(PAD_UP, 8'd0, 8'd0, 16'sd0, 16'sd8000, 32'd1019));
    add_poll(mk_poll(16'hFFFF, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd1020));
    // schedule wraps past the top of the time range
    add_poll(mk_poll(PAD_DOWN, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'hFFFF_FF00));
    add_poll(mk_poll(PAD_DOWN, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF));
    add_poll(mk_poll(PAD_DOWN, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'h0000_0010));
    // widest deadzone and lowest threshold, with upper data bits that must be dropped
    add_cfg(REG_STICK_DEADZONE, 16'hFFFF);
    add_cfg(REG_TRIGGER_THRESHOLD, 16'hFF00);
    add_cfg(REG_INITIAL_DELAY, 16'h0000);
    add_cfg(REG_REPEAT_INTERVAL, 16'h0000);
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, -16'sd32768, 16'sd32767, 32'd100));
    // zero delay and zero interval: repeats in the same millisecond once, then waits
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, -16'sd32768, 16'sd32767, 32'd100));
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, -16'sd32768, 16'sd32767, 32'd100));
    // no deadzone: a centered stick resolves to down
    add_cfg(REG_STICK_DEADZONE, 16'h0000);
    add_poll(mk_poll(16'h0, 8'd0, 8'd0, 16'sd0, 16'sd0, 32'd101));

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        send_poll(stim_tab[i].poll, stim_tab[i].typed, stim_tab[i].want);
      end
    end

    // random part over a spread of register settings
    set_regs(16'(DEADZONE_RST), 16'(THRESHOLD_RST), DELAY_RST, INTERVAL_RST);
    run_random(150);
    set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(150);
    set_regs(16'h7FFF, 16'h00FF, 16'hFFFF, 16'hFFFF);
    run_random(150);
    // start close to the top of the time range so the schedule wraps
    cur_time = 32'hFFFF_0000 + $urandom_range(0, 16'hF000);
    set_regs(16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom_range(0, 2000)),
             16'($urandom_range(0, 500)));
    run_random(150);
    // a stretch with neither sender gaps nor receiver stalls
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_regs(16'd1000, 16'd200, 16'd5, 16'd1);
    run_random(150);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_regs(16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom),
             16'($urandom_range(0, 300)));
    run_random(150);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d polls over %0d register writes; %0d result beats checked, %0d with a fire",
             polls_sent, reg_writes, results_seen, fires_seen);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[files.f]
sv/gnar_pkg.sv
sv/gnar_look.sv
sv/gnar_rem.sv
sv/gamepad_navigation_auto_repeat.sv
bench/tb_top.sv
